>>> src/msc_pkg.sv
// ----------------------------------------------------------------------------
// MI snoop cache pair package
// Geometry, line format and memory write requests shared by the cache pair.
// ----------------------------------------------------------------------------
`default_nettype none

package msc_pkg;

  localparam int LINE_COUNT  = 256;
  localparam int MEM_WORDS   = 1024;
  localparam int NUM_CACHES  = 2;

  localparam int IDX_W  = $clog2(LINE_COUNT);
  localparam int ADDR_W = $clog2(MEM_WORDS);
  localparam int TAG_W  = ADDR_W - IDX_W;
  localparam int DATA_W = 8;
  localparam int CNT_W  = 32;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [TAG_W-1:0]  tag_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [DATA_W-1:0] byte_t;
  typedef logic [CNT_W-1:0]  count_t;

  // Operation codes of a request.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef struct packed {
    logic  modified;
    tag_t  tag;
    byte_t data;
  } line_t;

  typedef struct packed {
    logic  en;
    idx_t  idx;
    line_t line;
  } line_wr_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
    byte_t data;
  } mem_wr_t;

endpackage

`default_nettype wire

>>> src/msc_ifs.sv
// ----------------------------------------------------------------------------
// MI snoop cache pair channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface msc_req_if;
  import msc_pkg::*;

  logic  valid;
  logic  ready;
  logic  requester;
  addr_t addr;
  logic  op;
  byte_t write_data;

  modport source (output valid, requester, addr, op, write_data, input ready);
  modport sink   (input valid, requester, addr, op, write_data, output ready);
endinterface

interface msc_rsp_if;
  import msc_pkg::*;

  logic   valid;
  logic   ready;
  byte_t  read_data;
  logic   hit;
  logic   snoop_writeback;
  logic   victim_writeback;
  count_t hit_total;
  count_t miss_total;

  modport source (output valid, read_data, hit, snoop_writeback, victim_writeback,
                  hit_total, miss_total, input ready);
  modport sink   (input valid, read_data, hit, snoop_writeback, victim_writeback,
                  hit_total, miss_total, output ready);
endinterface

`default_nettype wire

>>> src/msc_line_ram.sv
// ----------------------------------------------------------------------------
// Cache line store
// One cache's lines: state, tag and data byte, one write and one read port.
// ----------------------------------------------------------------------------
`default_nettype none

module msc_line_ram (
  input  wire logic             clk_i,
  input  wire logic             rd_en_i,
  input  wire msc_pkg::idx_t    rd_idx_i,
  output msc_pkg::line_t        rd_line_o,
  input  wire msc_pkg::line_wr_t wr_i
);
  import msc_pkg::*;

  line_t mem_q [LINE_COUNT];
  line_t rd_line_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.idx] <= wr_i.line;
    end
    if (rd_en_i) begin
      rd_line_q <= mem_q[rd_idx_i];
    end
  end

  assign rd_line_o = rd_line_q;

endmodule

`default_nettype wire

>>> src/msc_mem_ram.sv
// ----------------------------------------------------------------------------
// Shared byte memory
// Backing store behind both caches, one write and one read port.
// ----------------------------------------------------------------------------
`default_nettype none

module msc_mem_ram (
  input  wire logic             clk_i,
  input  wire logic             rd_en_i,
  input  wire msc_pkg::addr_t   rd_addr_i,
  output msc_pkg::byte_t        rd_data_o,
  input  wire msc_pkg::mem_wr_t wr_i
);
  import msc_pkg::*;

  byte_t mem_q [MEM_WORDS];
  byte_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

>>> src/mi_snoop_cache_pair.sv
// ----------------------------------------------------------------------------
// MI snoop cache pair
// A request is latched on acceptance and its response registered in ST_EXEC
// once the output is free; no new request is taken before ST_IDLE again. A
// Modified victim is written back in ST_VICTIM, as the shared memory has a
// single write port. Reset: a pass over MEM_WORDS (1024) addresses zeroes
// both line stores and the shared memory; no request is accepted until it ends.
// ----------------------------------------------------------------------------
`default_nettype none

module mi_snoop_cache_pair (
  input wire logic clk_i,
  input wire logic rst_ni,
  msc_req_if.sink  req_i,
  msc_rsp_if.source rsp_o
);
  import msc_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_VICTIM
  } state_e;

  state_e state_q;
  addr_t  clr_cnt_q;

  // Latched request.
  logic   req_sel_q;
  addr_t  addr_q;
  logic   op_q;
  byte_t  wdata_q;

  // Pending victim writeback.
  addr_t  victim_addr_q;
  byte_t  victim_data_q;

  count_t hit_cnt_q, hit_cnt_d;
  count_t miss_cnt_q, miss_cnt_d;

  logic   rsp_valid_q;
  byte_t  rsp_data_q;
  logic   rsp_hit_q;
  logic   rsp_snoop_q;
  logic   rsp_victim_q;
  count_t rsp_hit_total_q;
  count_t rsp_miss_total_q;

  line_t    rd_line [NUM_CACHES];
  line_wr_t line_wr [NUM_CACHES];
  byte_t    mem_rdata;
  mem_wr_t  mem_wr;

  logic  accept;
  logic  out_free;
  logic  fire;
  idx_t  idx;
  tag_t  tag;
  line_t req_line, oth_line;
  logic  snoop_wb, hit, victim_wb;
  byte_t fill_data, cur_data, new_data;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign out_free    = !rsp_valid_q || rsp_o.ready;
  assign fire        = (state_q == ST_EXEC) && out_free;

  for (genvar c = 0; c < NUM_CACHES; c++) begin : g_cache
    msc_line_ram u_line_ram (
      .clk_i     (clk_i),
      .rd_en_i   (accept),
      .rd_idx_i  (req_i.addr[IDX_W-1:0]),
      .rd_line_o (rd_line[c]),
      .wr_i      (line_wr[c])
    );
  end

  msc_mem_ram u_mem_ram (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (req_i.addr),
    .rd_data_o (mem_rdata),
    .wr_i      (mem_wr)
  );

  always_comb begin
    idx      = addr_q[IDX_W-1:0];
    tag      = addr_q[ADDR_W-1:IDX_W];
    req_line = rd_line[req_sel_q];
    oth_line = rd_line[!req_sel_q];

    snoop_wb  = oth_line.modified && (oth_line.tag == tag);
    hit       = req_line.modified && (req_line.tag == tag);
    victim_wb = !hit && req_line.modified;

    // A snoop writeback targets the same address the fill reads, so forward it.
    fill_data = snoop_wb ? oth_line.data : mem_rdata;
    cur_data  = hit ? req_line.data : fill_data;
    new_data  = (op_q == OP_READ) ? cur_data : wdata_q;

    hit_cnt_d  = hit_cnt_q + count_t'(hit);
    miss_cnt_d = miss_cnt_q + count_t'(!hit);
  end

  always_comb begin
    for (int c = 0; c < NUM_CACHES; c++) begin
      line_wr[c] = '0;
      if (state_q == ST_CLEAR) begin
        line_wr[c].en  = 1'b1;
        line_wr[c].idx = clr_cnt_q[IDX_W-1:0];
      end else if (fire && (c == int'(req_sel_q))) begin
        line_wr[c].en   = 1'b1;
        line_wr[c].idx  = idx;
        line_wr[c].line = '{modified: 1'b1, tag: tag, data: new_data};
      end else if (fire && snoop_wb) begin
        line_wr[c].en   = 1'b1;
        line_wr[c].idx  = idx;
        line_wr[c].line = '{modified: 1'b0, tag: oth_line.tag, data: oth_line.data};
      end
    end

    mem_wr = '0;
    case (state_q)
      ST_CLEAR: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = clr_cnt_q;
      end
      ST_EXEC: begin
        mem_wr.en   = fire && snoop_wb;
        mem_wr.addr = addr_q;
        mem_wr.data = oth_line.data;
      end
      ST_VICTIM: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = victim_addr_q;
        mem_wr.data = victim_data_q;
      end
      default: begin
        mem_wr = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_CLEAR;
      clr_cnt_q        <= '0;
      req_sel_q        <= 1'b0;
      addr_q           <= '0;
      op_q             <= OP_WRITE;
      wdata_q          <= '0;
      victim_addr_q    <= '0;
      victim_data_q    <= '0;
      hit_cnt_q        <= '0;
      miss_cnt_q       <= '0;
      rsp_valid_q      <= 1'b0;
      rsp_data_q       <= '0;
      rsp_hit_q        <= 1'b0;
      rsp_snoop_q      <= 1'b0;
      rsp_victim_q     <= 1'b0;
      rsp_hit_total_q  <= '0;
      rsp_miss_total_q <= '0;
    end else begin
      if (fire) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_valid_q && rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + addr_t'(1);
          if (clr_cnt_q == addr_t'(MEM_WORDS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            req_sel_q <= req_i.requester;
            addr_q    <= req_i.addr;
            op_q      <= req_i.op;
            wdata_q   <= req_i.write_data;
            state_q   <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          // The read data stays registered, so waiting here for the output is safe.
          if (out_free) begin
            hit_cnt_q        <= hit_cnt_d;
            miss_cnt_q       <= miss_cnt_d;
            rsp_data_q       <= new_data;
            rsp_hit_q        <= hit;
            rsp_snoop_q      <= snoop_wb;
            rsp_victim_q     <= victim_wb;
            rsp_hit_total_q  <= hit_cnt_d;
            rsp_miss_total_q <= miss_cnt_d;
            victim_addr_q    <= {req_line.tag, idx};
            victim_data_q    <= req_line.data;
            state_q          <= victim_wb ? ST_VICTIM : ST_IDLE;
          end
        end
        ST_VICTIM: begin
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid            = rsp_valid_q;
  assign rsp_o.read_data        = rsp_data_q;
  assign rsp_o.hit              = rsp_hit_q;
  assign rsp_o.snoop_writeback  = rsp_snoop_q;
  assign rsp_o.victim_writeback = rsp_victim_q;
  assign rsp_o.hit_total        = rsp_hit_total_q;
  assign rsp_o.miss_total       = rsp_miss_total_q;

endmodule

`default_nettype wire

>>> sim/mi_snoop_cache_pair_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MI snoop cache pair testbench
// Drives cache accesses from both requesters through the request channel and
// predicts every response with an own model of the two caches, the shared
// memory and the hit/miss counters. Responses are compared field by field in
// order. Both channels idle in random bursts, and the response side is held
// off once for a long stretch so that the block backs up its request path.
// ----------------------------------------------------------------------------

module mi_snoop_cache_pair_tb;
  import msc_pkg::*;

  localparam logic CPU0 = 1'b0;
  localparam logic CPU1 = 1'b1;

  localparam int RANDOM_ACCESSES = 700;
  localparam int TAIL_ACCESSES   = 60;
  localparam int HOLD_AT_RSP     = 200;
  localparam int HOLD_CYCLES     = 300;

  typedef struct packed {
    logic  requester;
    addr_t addr;
    logic  op;
    byte_t write_data;
  } access_t;

  typedef struct packed {
    byte_t  read_data;
    logic   hit;
    logic   snoop_wb;
    logic   victim_wb;
    count_t hit_total;
    count_t miss_total;
  } cache_rsp_t;

  logic clk;
  logic rst_n;

  msc_req_if req_bus ();
  msc_rsp_if rsp_bus ();

  mi_snoop_cache_pair u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Own copy of both caches, the shared memory and the counters.
  logic   line_dirty [NUM_CACHES][LINE_COUNT];
  tag_t   line_tags  [NUM_CACHES][LINE_COUNT];
  byte_t  line_data  [NUM_CACHES][LINE_COUNT];
  byte_t  backing_mem [MEM_WORDS];
  count_t hits_seen;
  count_t misses_seen;
  int     snoop_wb_seen;
  int     victim_wb_seen;

  access_t    access_queue [$];
  cache_rsp_t due_responses [$];

  int fail_count;
  int rsp_seen;
  int issued;

  // Applies one access to the coherence model and queues the response it owes.
  task automatic apply_access(input access_t acc);
    logic       other;
    idx_t       idx;
    tag_t       tag;
    cache_rsp_t rsp;
    other = ~acc.requester;
    idx   = acc.addr[IDX_W-1:0];
    tag   = acc.addr[ADDR_W-1:IDX_W];
    rsp   = '0;
    if (line_dirty[other][idx] && line_tags[other][idx] == tag) begin
      backing_mem[{tag, idx}] = line_data[other][idx];
      line_dirty[other][idx]  = 1'b0;
      rsp.snoop_wb            = 1'b1;
      snoop_wb_seen++;
    end
    rsp.hit = line_dirty[acc.requester][idx] && line_tags[acc.requester][idx] == tag;
    if (rsp.hit) begin
      hits_seen++;
    end else begin
      misses_seen++;
      if (line_dirty[acc.requester][idx]) begin
        backing_mem[{line_tags[acc.requester][idx], idx}] = line_data[acc.requester][idx];
        rsp.victim_wb = 1'b1;
        victim_wb_seen++;
      end
      line_data[acc.requester][idx] = backing_mem[{tag, idx}];
      line_tags[acc.requester][idx] = tag;
    end
    if (acc.op == OP_WRITE) line_data[acc.requester][idx] = acc.write_data;
    rsp.read_data                  = line_data[acc.requester][idx];
    line_dirty[acc.requester][idx] = 1'b1;
    rsp.hit_total                  = hits_seen;
    rsp.miss_total                 = misses_seen;
    due_responses.push_back(rsp);
  endtask

  task automatic queue_access(input logic who, input addr_t addr, input logic op,
                              input byte_t data);
    access_t acc;
    acc.requester  = who;
    acc.addr       = addr;
    acc.op         = op;
    acc.write_data = data;
    access_queue.push_back(acc);
  endtask

  task automatic check_field(input string name, input longint unsigned exp_val,
                             input longint unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  // Request driver.
  access_t cur_access;
  int      src_gap;
  int      src_idle_pct;
  logic    quiet_tail;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      req_bus.valid      <= 1'b0;
      req_bus.requester  <= 1'b0;
      req_bus.addr       <= '0;
      req_bus.op         <= OP_WRITE;
      req_bus.write_data <= '0;
      quiet_tail         <= 1'b0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        apply_access(cur_access);
        issued++;
      end
      quiet_tail <= (access_queue.size() < TAIL_ACCESSES);
      if (!req_bus.valid || req_bus.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          req_bus.valid <= 1'b0;
        end else if (access_queue.size() > 0 && !quiet_tail &&
                     $urandom_range(0, 99) < src_idle_pct) begin
          src_gap       = $urandom_range(1, 10) - 1;
          req_bus.valid <= 1'b0;
        end else if (access_queue.size() > 0) begin
          if (issued % 50 == 0) begin
            case ($urandom_range(0, 2))
              0: src_idle_pct = 0;
              1: src_idle_pct = 10;
              default: src_idle_pct = 40;
            endcase
          end
          cur_access         = access_queue.pop_front();
          req_bus.valid      <= 1'b1;
          req_bus.requester  <= cur_access.requester;
          req_bus.addr       <= cur_access.addr;
          req_bus.op         <= cur_access.op;
          req_bus.write_data <= cur_access.write_data;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // The response side is held off once, long enough for the block to fill.
  int   hold_cycles;
  logic hold_done;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      hold_cycles <= 0;
      hold_done   <= 1'b0;
    end else if (!hold_done && rsp_seen == HOLD_AT_RSP) begin
      hold_cycles <= HOLD_CYCLES;
      hold_done   <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // Response monitor.
  int sink_gap;
  int sink_idle_pct;

  always @(posedge clk or negedge rst_n) begin
    cache_rsp_t exp_rsp;
    if (!rst_n) begin
      rsp_bus.ready <= 1'b0;
      rsp_seen      <= 0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        rsp_seen <= rsp_seen + 1;
        if (due_responses.size() == 0) begin
          $error("response arrived with no access outstanding");
          fail_count++;
        end else begin
          exp_rsp = due_responses.pop_front();
          check_field("read_data", exp_rsp.read_data, rsp_bus.read_data);
          check_field("hit", exp_rsp.hit, rsp_bus.hit);
          check_field("snoop_writeback", exp_rsp.snoop_wb, rsp_bus.snoop_writeback);
          check_field("victim_writeback", exp_rsp.victim_wb, rsp_bus.victim_writeback);
          check_field("hit_total", exp_rsp.hit_total, rsp_bus.hit_total);
          check_field("miss_total", exp_rsp.miss_total, rsp_bus.miss_total);
        end
        if (rsp_seen % 50 == 0) begin
          case ($urandom_range(0, 2))
            0: sink_idle_pct = 0;
            1: sink_idle_pct = 15;
            default: sink_idle_pct = 45;
          endcase
        end
      end
      if (hold_cycles > 0) begin
        rsp_bus.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        rsp_bus.ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 99) < sink_idle_pct) begin
        sink_gap      = $urandom_range(1, 10) - 1;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    addr_t addr;
    int    pick;
    rst_n              = 1'b0;
    req_bus.valid      = 1'b0;
    req_bus.requester  = 1'b0;
    req_bus.addr       = '0;
    req_bus.op         = OP_WRITE;
    req_bus.write_data = '0;
    rsp_bus.ready      = 1'b0;
    fail_count         = 0;
    issued             = 0;
    src_gap            = 0;
    sink_gap           = 0;
    src_idle_pct       = 0;
    sink_idle_pct      = 0;
    hits_seen          = '0;
    misses_seen        = '0;
    snoop_wb_seen      = 0;
    victim_wb_seen     = 0;
    for (int c = 0; c < NUM_CACHES; c++) begin
      for (int i = 0; i < LINE_COUNT; i++) begin
        line_dirty[c][i] = 1'b0;
        line_tags[c][i]  = '0;
        line_data[c][i]  = '0;
      end
    end
    for (int m = 0; m < MEM_WORDS; m++) backing_mem[m] = '0;

    // Invalid line whose reset tag matches: a miss without a victim.
    queue_access(CPU0, 10'd0, OP_READ, 8'hFF);
    queue_access(CPU0, 10'd0, OP_WRITE, 8'hFF);
    queue_access(CPU0, 10'd0, OP_READ, 8'h00);
    // The other cache pulls the dirty byte through a snoop write-back.
    queue_access(CPU1, 10'd0, OP_READ, 8'h55);
    // Snooper holds a different tag at the index, so it stays put.
    queue_access(CPU0, 10'd256, OP_WRITE, 8'hAA);
    // Conflicting tags at one index force victim write-backs.
    queue_access(CPU0, 10'd512, OP_WRITE, 8'h5A);
    queue_access(CPU0, 10'd256, OP_READ, 8'h00);
    queue_access(CPU0, 10'd768, OP_WRITE, 8'hA5);
    queue_access(CPU1, 10'd768, OP_READ, 8'hFF);
    // Top of the address space, both tag bits and all index bits set.
    queue_access(CPU1, 10'd1023, OP_WRITE, 8'h00);
    queue_access(CPU1, 10'd1023, OP_WRITE, 8'hFF);
    queue_access(CPU0, 10'd1023, OP_READ, 8'h00);
    queue_access(CPU1, 10'd1023, OP_READ, 8'hAA);
    queue_access(CPU0, 10'd767, OP_WRITE, 8'h81);
    queue_access(CPU0, 10'd255, OP_READ, 8'h7E);
    queue_access(CPU1, 10'd511, OP_WRITE, 8'h01);
    queue_access(CPU1, 10'd255, OP_WRITE, 8'h80);
    queue_access(CPU0, 10'd511, OP_READ, 8'hFF);
    queue_access(CPU0, 10'd1, OP_WRITE, 8'h7F);
    queue_access(CPU1, 10'd513, OP_WRITE, 8'hFE);
    queue_access(CPU0, 10'd513, OP_READ, 8'h33);
    queue_access(CPU1, 10'd1, OP_READ, 8'hCC);

    // Most traffic stays on a few indexes so that tags collide and lines
    // bounce between the two caches.
    for (int n = 0; n < RANDOM_ACCESSES; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        addr = (addr_t'($urandom_range(0, 3)) << IDX_W) | addr_t'($urandom_range(0, 7));
      end else if (pick < 85) begin
        addr = (addr_t'($urandom_range(0, 3)) << IDX_W) | addr_t'($urandom_range(248, 255));
      end else begin
        addr = addr_t'($urandom_range(0, MEM_WORDS - 1));
      end
      queue_access(logic'($urandom_range(0, 1)), addr,
                   ($urandom_range(0, 2) != 0) ? OP_READ : OP_WRITE,
                   byte_t'($urandom_range(0, 255)));
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (access_queue.size() != 0 || req_bus.valid || due_responses.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);

    $display("Covered %0d accesses: %0d hits, %0d misses, %0d snoop write-backs,",
             issued, hits_seen, misses_seen, snoop_wb_seen);
    $display("%0d victim write-backs; responses were held off once for %0d cycles.",
             victim_wb_seen, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("[mi_snoop_cache_pair] OK");
    end else begin
      $display("[mi_snoop_cache_pair] ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $error("run did not complete in time");
    $display("[mi_snoop_cache_pair] ERROR");
    $finish;
  end

endmodule
